>>> src/tcun_pkg.sv
// tcun_pkg: shared types and constants for the triangle midpoint / unit normal block
// no dependencies
package tcun_pkg;

    localparam int COORD_W = 16;
    localparam int INDEX_W = 10;
    localparam int CROSS_W = 35;

    typedef enum logic
    {
        MODE_LOAD = 1'b0,
        MODE_TRI  = 1'b1
    } mode_t;

    // queued transaction between front and back
    typedef struct packed
    {
        logic               tri_op;
        logic [INDEX_W-1:0] idx_a;
        logic [INDEX_W-1:0] idx_b;
        logic [INDEX_W-1:0] idx_c;
        logic [COORD_W-1:0] lx;
        logic [COORD_W-1:0] ly;
        logic [COORD_W-1:0] lz;
    } cmd_t;

    typedef enum logic [4:0]
    {
        ST_IDLE,
        ST_RD_A,
        ST_RD_B,
        ST_RD_C,
        ST_RD_WAIT,
        ST_SUM,
        ST_MID,
        ST_EDGE,
        ST_MUL1,
        ST_MUL2,
        ST_CROSS,
        ST_NORM,
        ST_SQ,
        ST_SQRT,
        ST_DIV,
        ST_OUT
    } back_state_t;

endpackage

>>> src/tcun_front.sv
// tcun_front: input side, classifies transactions and holds a two-entry queue
// depends on tcun_pkg
module tcun_front
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  valid,
    output logic                  stall,
    input  logic                  mode,
    input  logic [9:0]            first_corner,
    input  logic [9:0]            second_corner,
    input  logic [9:0]            third_corner,
    input  logic [15:0]           load_x,
    input  logic [15:0]           load_y,
    input  logic [15:0]           load_z,
    output logic                  q_valid,
    output tcun_pkg::cmd_t        q_cmd,
    input  logic                  q_take
);
    import tcun_pkg::*;

    cmd_t       fifo_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;
    logic       push, pop;
    cmd_t       cmd_in;

    assign stall = (count_reg == 2'd2);
    assign push  = valid && !stall;
    assign pop   = q_take && (count_reg != 2'd0);

    always_comb
    begin
        cmd_in.tri_op = (mode == MODE_TRI);
        cmd_in.idx_a  = first_corner;
        cmd_in.idx_b  = second_corner;
        cmd_in.idx_c  = third_corner;
        cmd_in.lx     = load_x;
        cmd_in.ly     = load_y;
        cmd_in.lz     = load_z;
        wr_ptr_next   = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next   = pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next    = count_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            fifo_reg[wr_ptr_reg] <= cmd_in;
        end
    end

    assign q_valid = (count_reg != 2'd0);
    assign q_cmd   = fifo_reg[rd_ptr_reg];

endmodule

>>> src/tcun_back.sv
// tcun_back: vertex store and sequential triangle datapath
// depends on tcun_pkg
module tcun_back
#(
    parameter int VERTEX_DEPTH = 1024
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  q_valid,
    input  tcun_pkg::cmd_t        q_cmd,
    output logic                  q_take,
    output logic                  out_valid,
    input  logic                  out_stall,
    output logic signed [15:0]    mid_x,
    output logic signed [15:0]    mid_y,
    output logic signed [15:0]    mid_z,
    output logic signed [15:0]    unit_x,
    output logic signed [15:0]    unit_y,
    output logic signed [15:0]    unit_z,
    output logic                  degenerate
);
    import tcun_pkg::*;

    localparam int AW = (VERTEX_DEPTH > 1) ? $clog2(VERTEX_DEPTH) : 1;

    logic [47:0] mem [VERTEX_DEPTH];
    logic [47:0] rd_data_reg;
    logic [AW-1:0] rd_addr;
    logic        rd_en;

    back_state_t state_reg, state_next;
    cmd_t        cmd_reg;
    logic        oob_a_reg, oob_b_reg, oob_c_reg;

    logic signed [15:0] va_reg [3];
    logic signed [15:0] vb_reg [3];
    logic signed [15:0] vc_reg [3];
    logic signed [17:0] sum_reg [3];
    logic signed [16:0] e1_reg [3];
    logic signed [16:0] e2_reg [3];
    logic signed [33:0] p1_reg [3];
    logic signed [33:0] p2_reg [3];
    logic        [34:0] mag_reg [3];
    logic               neg_reg [3];
    logic        [63:0] n_reg;
    logic        [63:0] rem_reg;
    logic        [31:0] root_reg;
    logic        [5:0]  cnt_reg;
    logic        [1:0]  k_reg;
    logic        [47:0] dnum_reg;
    logic        [32:0] drem_reg;
    logic        [16:0] quo_reg;

    logic               out_valid_reg;
    logic signed [15:0] mid_reg [3];
    logic signed [15:0] unit_reg [3];
    logic               degen_reg;

    logic [34:0] mmax;
    logic        norm_done;

    logic oob;
    assign oob = ({{(32-INDEX_W){1'b0}}, q_cmd.idx_a} >= 32'(VERTEX_DEPTH));

    function automatic logic oob_of(input logic [INDEX_W-1:0] idx);
        oob_of = ({{(32-INDEX_W){1'b0}}, idx} >= 32'(VERTEX_DEPTH));
    endfunction

    function automatic logic [AW-1:0] addr_of(input logic [INDEX_W-1:0] idx);
        logic [31:0] wide;
        wide = {{(32-INDEX_W){1'b0}}, idx};
        addr_of = wide[AW-1:0];
    endfunction

    // store write on a load at the head of the queue
    always_ff @(posedge clk)
    begin
        if (state_reg == ST_IDLE && q_valid && !q_cmd.tri_op && !oob)
        begin
            mem[addr_of(q_cmd.idx_a)] <= {q_cmd.lx, q_cmd.ly, q_cmd.lz};
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    always_comb
    begin
        rd_en   = 1'b0;
        rd_addr = addr_of(cmd_reg.idx_a);
        case (state_reg)
            ST_RD_A: begin rd_en = 1'b1; rd_addr = addr_of(cmd_reg.idx_a); end
            ST_RD_B: begin rd_en = 1'b1; rd_addr = addr_of(cmd_reg.idx_b); end
            ST_RD_C: begin rd_en = 1'b1; rd_addr = addr_of(cmd_reg.idx_c); end
            default: ;
        endcase
    end

    assign q_take = (state_reg == ST_IDLE) && q_valid;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:    if (q_valid && q_cmd.tri_op) state_next = ST_RD_A;
            ST_RD_A:    state_next = ST_RD_B;
            ST_RD_B:    state_next = ST_RD_C;
            ST_RD_C:    state_next = ST_RD_WAIT;
            ST_RD_WAIT: state_next = ST_SUM;
            ST_SUM:     state_next = ST_MID;
            ST_MID:     state_next = ST_EDGE;
            ST_EDGE:    state_next = ST_MUL1;
            ST_MUL1:    state_next = ST_MUL2;
            ST_MUL2:    state_next = ST_CROSS;
            ST_CROSS:   state_next = ST_NORM;
            ST_NORM:
            begin
                if (mag_reg[0] == 35'd0 && mag_reg[1] == 35'd0 && mag_reg[2] == 35'd0)
                    state_next = ST_OUT;
                else if (norm_done)
                    state_next = ST_SQ;
            end
            ST_SQ:      if (k_reg == 2'd3) state_next = ST_SQRT;
            ST_SQRT:    if (cnt_reg == 6'd31) state_next = ST_DIV;
            ST_DIV:     if (cnt_reg == 6'd49 && k_reg == 2'd2) state_next = ST_OUT;
            ST_OUT:     if (!out_valid_reg || !out_stall) state_next = ST_IDLE;
            default:    state_next = ST_IDLE;
        endcase
    end

    // largest magnitude for normalization
    always_comb
    begin
        mmax = mag_reg[0];
        if (mag_reg[1] > mmax) mmax = mag_reg[1];
        if (mag_reg[2] > mmax) mmax = mag_reg[2];
        norm_done = (mmax[34:31] == 4'd0) && mmax[30];
    end

    // square accumulation and restoring square root / division steps
    logic [63:0] sq;
    logic [31:0] mk31;
    logic [65:0] trial;
    logic [65:0] rem_sh;
    logic [34:0] dsub;
    logic [33:0] dsh;
    always_comb
    begin
        mk31   = mag_reg[k_reg == 2'd3 ? 2'd0 : k_reg][31:0];
        sq     = {32'd0, mk31} * {32'd0, mk31};
        rem_sh = {rem_reg, n_reg[63:62]};
        trial  = {32'd0, root_reg, 2'b01};
        dsh    = {drem_reg, dnum_reg[47]};
        dsub   = {1'b0, dsh} - {2'b00, root_reg, 1'b0};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (out_valid_reg && !out_stall)
                out_valid_reg <= 1'b0;
            if (state_reg == ST_OUT && (!out_valid_reg || !out_stall))
                out_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            ST_IDLE:
            begin
                cmd_reg   <= q_cmd;
                oob_a_reg <= oob_of(q_cmd.idx_a);
                oob_b_reg <= oob_of(q_cmd.idx_b);
                oob_c_reg <= oob_of(q_cmd.idx_c);
            end
            ST_RD_B:
            begin
                va_reg[0] <= oob_a_reg ? 16'sd0 : rd_data_reg[47:32];
                va_reg[1] <= oob_a_reg ? 16'sd0 : rd_data_reg[31:16];
                va_reg[2] <= oob_a_reg ? 16'sd0 : rd_data_reg[15:0];
            end
            ST_RD_C:
            begin
                vb_reg[0] <= oob_b_reg ? 16'sd0 : rd_data_reg[47:32];
                vb_reg[1] <= oob_b_reg ? 16'sd0 : rd_data_reg[31:16];
                vb_reg[2] <= oob_b_reg ? 16'sd0 : rd_data_reg[15:0];
            end
            ST_RD_WAIT:
            begin
                vc_reg[0] <= oob_c_reg ? 16'sd0 : rd_data_reg[47:32];
                vc_reg[1] <= oob_c_reg ? 16'sd0 : rd_data_reg[31:16];
                vc_reg[2] <= oob_c_reg ? 16'sd0 : rd_data_reg[15:0];
            end
            ST_SUM:
            begin
                for (int i = 0; i < 3; i++)
                begin
                    sum_reg[i] <= 18'(va_reg[i]) + 18'(vb_reg[i]) + 18'(vc_reg[i]) + 18'sd1;
                end
            end
            ST_MID:
            begin
                // floor((s+1)/3) via reciprocal multiply on biased value
                for (int i = 0; i < 3; i++)
                begin
                    logic [18:0] b;
                    logic [38:0] pr;
                    b  = 19'(sum_reg[i]) + 19'd196608;
                    pr = {20'd0, b} * 39'd174763;
                    mid_reg[i] <= 16'(20'(pr[38:19]) - 20'd65536);
                end
            end
            ST_EDGE:
            begin
                for (int i = 0; i < 3; i++)
                begin
                    e1_reg[i] <= 17'(vb_reg[i]) - 17'(va_reg[i]);
                    e2_reg[i] <= 17'(vc_reg[i]) - 17'(va_reg[i]);
                end
            end
            ST_MUL1:
            begin
                p1_reg[0] <= e1_reg[1] * e2_reg[2];
                p1_reg[1] <= e1_reg[2] * e2_reg[0];
                p1_reg[2] <= e1_reg[0] * e2_reg[1];
            end
            ST_MUL2:
            begin
                p2_reg[0] <= e1_reg[2] * e2_reg[1];
                p2_reg[1] <= e1_reg[0] * e2_reg[2];
                p2_reg[2] <= e1_reg[1] * e2_reg[0];
            end
            ST_CROSS:
            begin
                for (int i = 0; i < 3; i++)
                begin
                    logic signed [34:0] c;
                    c = 35'(p1_reg[i]) - 35'(p2_reg[i]);
                    neg_reg[i] <= c[34];
                    mag_reg[i] <= c[34] ? 35'(-c) : c;
                end
                k_reg <= 2'd0;
                n_reg <= 64'd0;
            end
            ST_NORM:
            begin
                if (mmax[34:31] != 4'd0)
                    for (int i = 0; i < 3; i++) mag_reg[i] <= mag_reg[i] >> 1;
                else if (!mmax[30] && mmax != 35'd0)
                    for (int i = 0; i < 3; i++) mag_reg[i] <= mag_reg[i] << 1;
            end
            ST_SQ:
            begin
                if (k_reg != 2'd3)
                begin
                    n_reg <= n_reg + sq;
                    k_reg <= k_reg + 2'd1;
                end
                rem_reg  <= 64'd0;
                root_reg <= 32'd0;
                cnt_reg  <= 6'd0;
            end
            ST_SQRT:
            begin
                if (rem_sh >= trial)
                begin
                    rem_reg  <= 64'(rem_sh - trial);
                    root_reg <= {root_reg[30:0], 1'b1};
                end
                else
                begin
                    rem_reg  <= rem_sh[63:0];
                    root_reg <= {root_reg[30:0], 1'b0};
                end
                n_reg   <= {n_reg[61:0], 2'b00};
                cnt_reg <= (cnt_reg == 6'd31) ? 6'd0 : cnt_reg + 6'd1;
                k_reg   <= 2'd0;
            end
            ST_DIV:
            begin
                if (cnt_reg == 6'd0)
                begin
                    dnum_reg <= ({13'd0, mag_reg[k_reg]} << 15) + {16'd0, root_reg};
                    drem_reg <= 33'd0;
                    quo_reg  <= 17'd0;
                    cnt_reg  <= 6'd1;
                end
                else if (cnt_reg < 6'd49)
                begin
                    // one quotient bit per cycle over 48 numerator bits
                    if (!dsub[34])
                    begin
                        drem_reg <= dsub[32:0];
                        quo_reg  <= {quo_reg[15:0], 1'b1};
                    end
                    else
                    begin
                        drem_reg <= dsh[32:0];
                        quo_reg  <= {quo_reg[15:0], 1'b0};
                    end
                    dnum_reg <= {dnum_reg[46:0], 1'b0};
                    cnt_reg  <= cnt_reg + 6'd1;
                end
                else
                begin
                    unit_reg[k_reg] <= neg_reg[k_reg] ? 16'(-quo_reg) : 16'(quo_reg);
                    cnt_reg <= 6'd0;
                    k_reg   <= k_reg + 2'd1;
                end
            end
            ST_OUT:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    degen_reg <= (mag_reg[0] == 35'd0 && mag_reg[1] == 35'd0
                                  && mag_reg[2] == 35'd0);
                    mid_x <= mid_reg[0];
                    mid_y <= mid_reg[1];
                    mid_z <= mid_reg[2];
                    if (mag_reg[0] == 35'd0 && mag_reg[1] == 35'd0 && mag_reg[2] == 35'd0)
                    begin
                        unit_x <= 16'sd0;
                        unit_y <= 16'sd0;
                        unit_z <= 16'sd0;
                    end
                    else
                    begin
                        unit_x <= unit_reg[0];
                        unit_y <= unit_reg[1];
                        unit_z <= unit_reg[2];
                    end
                end
            end
            default: ;
        endcase
    end

    assign out_valid  = out_valid_reg;
    assign degenerate = degen_reg;

endmodule

>>> src/triangle_centroid_unit_normal_unit.sv
// triangle_centroid_unit_normal_unit: top level of the triangle midpoint and unit normal block
// depends on tcun_pkg, tcun_front, tcun_back
//
// The block keeps a store of VERTEX_DEPTH signed Q8.8 vertices. A load transaction
// (mode 0) writes one vertex and gives no result; a triangle transaction (mode 1)
// reads three corners and returns the rounded face midpoint and the Q1.14 unit
// normal of (v2-v1) x (v3-v1), with degenerate set and a zero normal when the cross
// product vanishes. A two-entry queue decouples input from the sequencer, which
// works on one transaction at a time: a load retires while the sequencer is idle, a
// triangle holds the sequencer through the reads and products, the normalising shifts,
// the sum of squares, a 32-step square root and three divisions that share one
// restoring unit, then the result register; a degenerate triangle goes from the
// normalising state straight to the result. Corners beyond the store read as zero.
module triangle_centroid_unit_normal_unit
#(
    parameter int VERTEX_DEPTH = 1024
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic               mode,
    input  logic [9:0]         first_corner,
    input  logic [9:0]         second_corner,
    input  logic [9:0]         third_corner,
    input  logic signed [15:0] load_x,
    input  logic signed [15:0] load_y,
    input  logic signed [15:0] load_z,
    output logic               out_valid,
    input  logic               out_stall,
    output logic signed [15:0] mid_x,
    output logic signed [15:0] mid_y,
    output logic signed [15:0] mid_z,
    output logic signed [15:0] unit_x,
    output logic signed [15:0] unit_y,
    output logic signed [15:0] unit_z,
    output logic               degenerate
);
    import tcun_pkg::*;

    logic q_valid;
    logic q_take;
    cmd_t q_cmd;

    // front: accepts transactions into the queue
    tcun_front u_front
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .valid        (in_valid),
        .stall        (in_stall),
        .mode         (mode),
        .first_corner (first_corner),
        .second_corner(second_corner),
        .third_corner (third_corner),
        .load_x       (load_x),
        .load_y       (load_y),
        .load_z       (load_z),
        .q_valid      (q_valid),
        .q_cmd        (q_cmd),
        .q_take       (q_take)
    );

    // back: store, midpoint and normalisation sequencer
    tcun_back #(.VERTEX_DEPTH(VERTEX_DEPTH)) u_back
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (q_valid),
        .q_cmd     (q_cmd),
        .q_take    (q_take),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .mid_x     (mid_x),
        .mid_y     (mid_y),
        .mid_z     (mid_z),
        .unit_x    (unit_x),
        .unit_y    (unit_y),
        .unit_z    (unit_z),
        .degenerate(degenerate)
    );

endmodule

>>> src/tcun_checker.sv
// tcun_port_checks: port-level checks for the triangle block, bound to the top level
// depends on triangle_centroid_unit_normal_unit
module tcun_port_checks
(
    input logic               clk,
    input logic               rst_n,
    input logic               out_valid,
    input logic               out_stall,
    input logic signed [15:0] unit_x,
    input logic signed [15:0] unit_y,
    input logic signed [15:0] unit_z,
    input logic               degenerate
);
    // stalled result holds its unit_x and degenerate fields
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(unit_x) && $stable(degenerate))
        else $error("result changed while stalled");

    // degenerate result carries zero normal
    a_degen: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && degenerate |-> unit_x == 16'sd0 && unit_y == 16'sd0 && unit_z == 16'sd0)
        else $error("degenerate result with nonzero normal");

    // normal x component stays in Q1.14 range
    a_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> unit_x <= 16'sd16384 && unit_x >= -16'sd16384)
        else $error("normal out of range");

    // nothing appears straight out of reset
    a_reset: assert property (@(posedge clk)
        !rst_n |=> !out_valid)
        else $error("result after reset");
endmodule

bind triangle_centroid_unit_normal_unit tcun_port_checks u_tcun_port_checks
(
    .clk       (clk),
    .rst_n     (rst_n),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .unit_x    (unit_x),
    .unit_y    (unit_y),
    .unit_z    (unit_z),
    .degenerate(degenerate)
);

>>> bench/tcun_checker.sv
// tcun_checker: watches both channels of the triangle midpoint / unit normal block,
// predicts each result and compares it field by field; depends on tcun_pkg
`timescale 1ns / 100ps

module tcun_checker
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    input  logic               in_stall,
    input  logic               mode,
    input  logic [9:0]         first_corner,
    input  logic [9:0]         second_corner,
    input  logic [9:0]         third_corner,
    input  logic signed [15:0] load_x,
    input  logic signed [15:0] load_y,
    input  logic signed [15:0] load_z,
    input  logic               out_valid,
    input  logic               out_stall,
    input  logic signed [15:0] mid_x,
    input  logic signed [15:0] mid_y,
    input  logic signed [15:0] mid_z,
    input  logic signed [15:0] unit_x,
    input  logic signed [15:0] unit_y,
    input  logic signed [15:0] unit_z,
    input  logic               degenerate,
    output int                 fail_count,
    output int                 pending
);
    import tcun_pkg::*;

    localparam int DEPTH = 1024;

    typedef struct packed
    {
        logic signed [15:0] mx;
        logic signed [15:0] my;
        logic signed [15:0] mz;
        logic signed [15:0] ux;
        logic signed [15:0] uy;
        logic signed [15:0] uz;
        logic               degen;
    } face_t;

    // only entries already written are ever read
    logic signed [15:0] vx [DEPTH];
    logic signed [15:0] vy [DEPTH];
    logic signed [15:0] vz [DEPTH];
    face_t faces_due [$];

    function automatic longint unsigned root_floor(longint unsigned n);
        longint unsigned r;
        longint unsigned b;
        r = 0;
        b = 64'd1 << 62;
        while (b > n)
            b = b >> 2;
        while (b != 0)
        begin
            if (n >= r + b)
            begin
                n = n - (r + b);
                r = (r >> 1) + b;
            end
            else
                r = r >> 1;
            b = b >> 2;
        end
        return r;
    endfunction

    function automatic face_t face_of(int a, int b, int c);
        face_t f;
        longint p [3][3];
        longint e1 [3];
        longint e2 [3];
        longint cr [3];
        longint unsigned mg [3];
        longint unsigned top;
        longint unsigned n;
        longint unsigned len;
        longint unsigned u;
        longint s;
        int k;
        p[0] = '{vx[a], vy[a], vz[a]};
        p[1] = '{vx[b], vy[b], vz[b]};
        p[2] = '{vx[c], vy[c], vz[c]};
        for (k = 0; k < 3; k++)
        begin
            s = p[0][k] + p[1][k] + p[2][k] + 1 + 3 * 65536;
            s = s / 3 - 65536;
            if (k == 0) f.mx = s[15:0];
            else if (k == 1) f.my = s[15:0];
            else f.mz = s[15:0];
            e1[k] = p[1][k] - p[0][k];
            e2[k] = p[2][k] - p[0][k];
        end
        cr[0] = e1[1] * e2[2] - e1[2] * e2[1];
        cr[1] = e1[2] * e2[0] - e1[0] * e2[2];
        cr[2] = e1[0] * e2[1] - e1[1] * e2[0];
        top = 0;
        for (k = 0; k < 3; k++)
        begin
            mg[k] = cr[k] < 0 ? -cr[k] : cr[k];
            if (mg[k] > top) top = mg[k];
        end
        f.ux = '0; f.uy = '0; f.uz = '0;
        f.degen = (top == 0);
        if (top == 0)
            return f;
        while (top >= 64'd1 << 31)
        begin
            top = top >> 1;
            for (k = 0; k < 3; k++) mg[k] = mg[k] >> 1;
        end
        while (top < 64'd1 << 30)
        begin
            top = top << 1;
            for (k = 0; k < 3; k++) mg[k] = mg[k] << 1;
        end
        n = mg[0] * mg[0] + mg[1] * mg[1] + mg[2] * mg[2];
        len = root_floor(n);
        for (k = 0; k < 3; k++)
        begin
            u = ((mg[k] << 15) + len) / (len << 1);
            s = cr[k] < 0 ? -longint'(u) : longint'(u);
            if (k == 0) f.ux = s[15:0];
            else if (k == 1) f.uy = s[15:0];
            else f.uz = s[15:0];
        end
        return f;
    endfunction

    task automatic check_field(string name, int want, int got);
        if (want != got)
        begin
            $error("%s: expected %0d, actual %0d", name, want, got);
            fail_count++;
        end
    endtask

    assign pending = faces_due.size();

    always @(posedge clk)
    begin
        face_t want;
        if (rst_n && in_valid && !in_stall)
        begin
            if (mode_t'(mode) == MODE_LOAD)
            begin
                vx[first_corner] = load_x;
                vy[first_corner] = load_y;
                vz[first_corner] = load_z;
            end
            else
                faces_due.push_back(face_of(first_corner, second_corner, third_corner));
        end
        if (rst_n && out_valid && !out_stall)
        begin
            if (faces_due.size() == 0)
            begin
                $error("result transaction with none expected");
                fail_count++;
            end
            else
            begin
                want = faces_due.pop_front();
                check_field("mid_x", want.mx, mid_x);
                check_field("mid_y", want.my, mid_y);
                check_field("mid_z", want.mz, mid_z);
                check_field("unit_x", want.ux, unit_x);
                check_field("unit_y", want.uy, unit_y);
                check_field("unit_z", want.uz, unit_z);
                check_field("degenerate", want.degen, degenerate);
            end
        end
    end

endmodule

>>> bench/triangle_centroid_unit_normal_unit_tb.sv
// triangle_centroid_unit_normal_unit_tb: stimulus and verdict for the triangle block
// depends on tcun_pkg, triangle_centroid_unit_normal_unit and tcun_checker
`timescale 1ns / 100ps

module triangle_centroid_unit_normal_unit_tb;
    import tcun_pkg::*;

    logic               clk;
    logic               rst_n;
    logic               in_valid;
    logic               in_stall;
    logic               mode;
    logic [9:0]         first_corner;
    logic [9:0]         second_corner;
    logic [9:0]         third_corner;
    logic signed [15:0] load_x;
    logic signed [15:0] load_y;
    logic signed [15:0] load_z;
    logic               out_valid;
    logic               out_stall;
    logic signed [15:0] mid_x;
    logic signed [15:0] mid_y;
    logic signed [15:0] mid_z;
    logic signed [15:0] unit_x;
    logic signed [15:0] unit_y;
    logic signed [15:0] unit_z;
    logic               degenerate;
    int                 fail_count;
    int                 pending;

    // idle rates in percent, changed per phase
    int send_idle_pct;
    int stall_pct;
    int hold_cycles;
    // which entries have been written so far: only those may be read
    bit written [1024];
    int written_list [$];

    triangle_centroid_unit_normal_unit i_dut
    (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall),
        .mode(mode), .first_corner(first_corner),
        .second_corner(second_corner), .third_corner(third_corner),
        .load_x(load_x), .load_y(load_y), .load_z(load_z),
        .out_valid(out_valid), .out_stall(out_stall),
        .mid_x(mid_x), .mid_y(mid_y), .mid_z(mid_z),
        .unit_x(unit_x), .unit_y(unit_y), .unit_z(unit_z),
        .degenerate(degenerate)
    );

    tcun_checker i_checker
    (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall),
        .mode(mode), .first_corner(first_corner),
        .second_corner(second_corner), .third_corner(third_corner),
        .load_x(load_x), .load_y(load_y), .load_z(load_z),
        .out_valid(out_valid), .out_stall(out_stall),
        .mid_x(mid_x), .mid_y(mid_y), .mid_z(mid_z),
        .unit_x(unit_x), .unit_y(unit_y), .unit_z(unit_z),
        .degenerate(degenerate),
        .fail_count(fail_count), .pending(pending)
    );

    initial clk = 1'b0;
    always #1 clk = ~clk;

    // receiver: random stall, or a long counted hold-off when asked
    always @(negedge clk)
    begin
        if (hold_cycles > 0)
        begin
            out_stall <= 1'b1;
            hold_cycles <= hold_cycles - 1;
        end
        else
            out_stall <= ($urandom_range(99) < stall_pct);
    end

    // one transaction: optional idle gaps, then hold valid until accepted;
    // valid stays up so a following transaction can go straight out
    task automatic send(logic m, logic [9:0] a, logic [9:0] b, logic [9:0] c,
                        logic [15:0] x, logic [15:0] y, logic [15:0] z);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid      <= 1'b1;
        mode          <= m;
        first_corner  <= a;
        second_corner <= b;
        third_corner  <= c;
        load_x        <= x;
        load_y        <= y;
        load_z        <= z;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        @(negedge clk);
        if (m == MODE_LOAD && !written[a])
        begin
            written[a] = 1'b1;
            written_list.push_back(a);
        end
    endtask

    task automatic load_vertex(int idx, logic [15:0] x, logic [15:0] y, logic [15:0] z);
        send(MODE_LOAD, idx[9:0], 10'($urandom), 10'($urandom), x, y, z);
    endtask

    // triangle over three already written entries, load fields random noise
    task automatic tri_face(int a, int b, int c);
        send(MODE_TRI, a[9:0], b[9:0], c[9:0], 16'($urandom), 16'($urandom), 16'($urandom));
    endtask

    function automatic int any_written();
        return written_list[$urandom_range(written_list.size() - 1)];
    endfunction

    function automatic logic [15:0] rand_coord();
        int pick;
        pick = $urandom_range(9);
        // mostly wide values, some extremes and some small ones
        if (pick == 0) return 16'h8000;
        if (pick == 1) return 16'h7fff;
        if (pick < 4) return 16'($signed($urandom_range(512)) - 256);
        return 16'($urandom);
    endfunction

    task automatic drain();
        in_valid <= 1'b0;
        while (pending != 0)
            @(negedge clk);
    endtask

    task automatic random_phase(int count);
        int kind;
        for (int n = 0; n < count; n++)
        begin
            kind = $urandom_range(99);
            if (kind < 35)
                load_vertex($urandom_range(1023), rand_coord(), rand_coord(), rand_coord());
            else if (kind < 45)
                // repeated corner gives a degenerate face
                begin
                    int r;
                    r = any_written();
                    tri_face(r, r, any_written());
                end
            else
                tri_face(any_written(), any_written(), any_written());
        end
    endtask

    initial
    begin
        rst_n         = 1'b0;
        in_valid      = 1'b0;
        mode          = MODE_LOAD;
        first_corner  = '0;
        second_corner = '0;
        third_corner  = '0;
        load_x        = '0;
        load_y        = '0;
        load_z        = '0;
        out_stall     = 1'b0;
        send_idle_pct = 0;
        stall_pct     = 0;
        hold_cycles   = 0;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // directed: extremes of coordinates and indices
        load_vertex(0, 16'h8000, 16'h8000, 16'h8000);
        load_vertex(1023, 16'h7fff, 16'h7fff, 16'h7fff);
        load_vertex(1, 16'h7fff, 16'h8000, 16'h0000);
        load_vertex(2, 16'h8000, 16'h7fff, 16'h7fff);
        load_vertex(3, 16'h0100, 16'h0000, 16'h0000);
        load_vertex(4, 16'h0000, 16'h0100, 16'h0000);
        load_vertex(5, 16'h0000, 16'h0000, 16'h0000);
        load_vertex(682, 16'h5555, 16'haaaa, 16'h0001);
        load_vertex(341, 16'haaaa, 16'h5555, 16'hfffe);
        tri_face(5, 3, 4);          // small right angle, unit z
        tri_face(0, 1023, 1);       // large cross product
        tri_face(0, 0, 0);          // all corners equal: degenerate
        tri_face(0, 5, 1023);       // collinear through origin: degenerate
        tri_face(1023, 1023, 2);
        tri_face(1, 2, 682);
        tri_face(682, 341, 0);
        tri_face(2, 1, 1023);
        tri_face(3, 4, 5);
        drain();

        // phases: no idling, sender idle, receiver stalling, both
        random_phase(500);
        send_idle_pct = 83;
        random_phase(350);
        send_idle_pct = 0;
        stall_pct = 83;
        random_phase(350);
        send_idle_pct = 31;
        stall_pct = 31;
        random_phase(350);

        // long receiver hold-off while the sender keeps offering: queue fills
        send_idle_pct = 0;
        stall_pct = 0;
        hold_cycles = 3000;
        random_phase(40);
        // sender pauses until every result is back
        drain();
        random_phase(400);

        drain();
        repeat (300) @(negedge clk);
        if (fail_count == 0)
            $display("triangle_centroid_unit_normal_unit test passed");
        else
            $display("triangle_centroid_unit_normal_unit test failed");
        $finish;
    end

    // watchdog: ends the run as failed if it has not finished
    initial
    begin
        #8000000;
        $display("triangle_centroid_unit_normal_unit test failed");
        $finish;
    end

endmodule
